// ===== hw/rtl/bfc_pkg.sv =====
// Shared types, sizes and helpers for the 3x3 clamped box filter.
// Used by the result queue and by the filter top level; depends on nothing.
`default_nettype none

package bfc_pkg;

   // Frame limits and derived widths
   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int CFG_W      = 10;
   localparam int PIX_W      = 8;
   localparam int LINE_W     = 2 * PIX_W;     // {upper, middle} per column
   localparam int COLSUM_W   = 10;            // three pixels, or upper + 2*middle
   localparam int SUM_W      = 12;            // nine pixels

   // Divide by nine: floor(s * 7282 / 2^16) is exact for s below 32768
   localparam int DIV9_MUL   = 7282;
   localparam int DIV9_MUL_W = 13;
   localparam int DIV9_SHIFT = 16;

   // Result queue (depth is a power of two so pointers wrap on their own)
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   // Request codes
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(400);
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(400);

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_PIXEL = 2'd1,
      OP_DRAIN = 2'd2
   } op_type;

   // One delivered result word
   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic [COL_W-1:0] out_col;
      logic [ROW_W-1:0] out_row;
      logic             frame_done;
      logic             run_end;
   } result_type;

   // Up to two result words entering the queue in one cycle, a before b
   typedef struct packed {
      logic       valid_a;
      logic       valid_b;
      result_type a;
      result_type b;
   } push_type;

   // Clamp a size register to 1..max
   function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] max_v);
      logic [CFG_W-1:0] r;
      begin
         if (v == '0) begin
            r = CFG_W'(1);
         end else if (v > max_v) begin
            r = max_v;
         end else begin
            r = v;
         end
         return r;
      end
   endfunction

   // Floor of a window sum divided by nine
   function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] s);
      logic [SUM_W+DIV9_MUL_W-1:0] prod;
      begin
         prod = (SUM_W+DIV9_MUL_W)'(s) * (SUM_W+DIV9_MUL_W)'(DIV9_MUL);
         return prod[DIV9_SHIFT +: PIX_W];
      end
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bfc_rsp_fifo.sv =====
// Result queue of the box filter: takes up to two words a cycle, gives one.
// Depends on bfc_pkg for the word and push types and the queue depth.
`default_nettype none

module bfc_rsp_fifo (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bfc_pkg::push_type             push,
   input  wire logic                          pop,
   output      bfc_pkg::result_type           head,
   output      logic                          not_empty,
   output      logic [bfc_pkg::FIFO_CNT_W-1:0] count
);

   bfc_pkg::result_type                   entry_ff [bfc_pkg::FIFO_DEPTH];
   logic [bfc_pkg::FIFO_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [bfc_pkg::FIFO_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [bfc_pkg::FIFO_CNT_W-1:0]        count_ff, count_in;
   logic [bfc_pkg::FIFO_PTR_W-1:0]        wr_b_ptr;

   // Advance pointers and count
   always_comb begin
      wr_b_ptr  = wr_ptr_ff + bfc_pkg::FIFO_PTR_W'(push.valid_a);
      wr_ptr_in = wr_b_ptr + bfc_pkg::FIFO_PTR_W'(push.valid_b);
      rd_ptr_in = rd_ptr_ff + bfc_pkg::FIFO_PTR_W'(pop);
      count_in  = count_ff + bfc_pkg::FIFO_CNT_W'(push.valid_a)
                 + bfc_pkg::FIFO_CNT_W'(push.valid_b) - bfc_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store words, second one right behind the first
   always_ff @(posedge clock) begin
      if (push.valid_a) begin
         entry_ff[wr_ptr_ff] <= push.a;
      end
      if (push.valid_b) begin
         entry_ff[wr_b_ptr] <= push.b;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/box_filter_3x3_clamped.sv =====
// 3x3 mean filter with edge clamping over a raster stream of 8-bit grey pixels.
// Depends on bfc_pkg and on bfc_rsp_fifo for the result queue.
`default_nettype none

// One request word is taken every clock while req_stall is low, pixel or flush
// alike. The previous two rows live in a single 512 x 16 synchronous line
// memory ({upper, middle} per column) that is read when a word is taken and
// written back in the following cycle, with a forwarding path for a read of
// the column being written. Row r comes out while row r+1 streams in: no
// result on a row's first pixel, one on each later one and one more on its
// last; row 0 gives none. The last row is drained by flush words, one result
// each, and frame_done marks its last column. Pixels sent while the last row
// drains and flushes with nothing pending are dropped without a result. Results
// pass the stage-2 and stage-3 registers and the result queue to the rsp port.
// req_stall rises only when the 8-word result queue, counting the results
// still in the three-stage pipeline, could not take two more. The line memory
// needs no clearing pass after reset. A write to the frame size registers
// applies from the next word on, also in the middle of a frame.
module box_filter_3x3_clamped (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic                            req_type,
   input  wire logic [bfc_pkg::PIX_W-1:0]       req_pixel_in,
   // result channel
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic [bfc_pkg::PIX_W-1:0]       rsp_pixel_out,
   output      logic [bfc_pkg::COL_W-1:0]       rsp_out_col,
   output      logic [bfc_pkg::ROW_W-1:0]       rsp_out_row,
   output      logic                            rsp_frame_done,
   output      logic                            rsp_run_end,
   // register write channel
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [bfc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bfc_pkg::CFG_W-1:0]       csr_wdata
);

   // Work carried from the accept stage to the memory-data stage
   typedef struct packed {
      bfc_pkg::op_type             op;
      logic [bfc_pkg::COL_W-1:0]   addr;
      logic [bfc_pkg::PIX_W-1:0]   px;
      logic                        row0;
      logic                        col_first;
      logic                        emit_prev;
      logic                        emit_cur;
      logic                        drain_start;
      logic                        last;
      logic [bfc_pkg::COL_W-1:0]   col;
      logic [bfc_pkg::ROW_W-1:0]   row;
      logic [1:0]                  nres;
   } s2_type;

   // A result before the divide
   typedef struct packed {
      logic [bfc_pkg::SUM_W-1:0]   sum;
      logic [bfc_pkg::COL_W-1:0]   col;
      logic [bfc_pkg::ROW_W-1:0]   row;
      logic                        done;
      logic                        run_end;
   } pend_type;

   typedef struct packed {
      logic     valid_a;
      logic     valid_b;
      pend_type a;
      pend_type b;
   } s3_type;

   // Configuration
   logic [bfc_pkg::CFG_W-1:0]    frame_width_ff, frame_width_in;
   logic [bfc_pkg::CFG_W-1:0]    frame_height_ff, frame_height_in;
   logic [bfc_pkg::CFG_W-1:0]    w_eff, h_eff;

   // Sequencing state
   logic [bfc_pkg::ROW_W-1:0]    in_row_ff, in_row_in;
   logic [bfc_pkg::COL_W-1:0]    in_col_ff, in_col_in;
   logic [bfc_pkg::COL_W-1:0]    drain_col_ff, drain_col_in;
   logic                         draining_ff, draining_in;

   // Pipeline
   logic                         req_take;
   logic [bfc_pkg::COL_W-1:0]    rd_addr;
   s2_type                       s2_ff, s2_in;
   s3_type                       s3_ff, s3_in;

   // Line memory and forwarding
   logic [bfc_pkg::LINE_W-1:0]   line_mem [bfc_pkg::MAX_WIDTH];
   logic [bfc_pkg::LINE_W-1:0]   ram_rd_ff;
   logic                         fwd_hit_ff, fwd_hit_in;
   logic [bfc_pkg::LINE_W-1:0]   fwd_word_ff, fwd_word_in;
   logic [bfc_pkg::LINE_W-1:0]   rd_word;
   logic                         wr_en;
   logic [bfc_pkg::LINE_W-1:0]   wr_word;

   // Window column sums, left to right, and drain window
   logic [bfc_pkg::COLSUM_W-1:0] cs0_ff, cs1_ff, cs2_ff;
   logic [bfc_pkg::COLSUM_W-1:0] cs0_in, cs1_in, cs2_in;
   logic [bfc_pkg::COLSUM_W-1:0] dprev_ff, dprev_in, dcur_ff, dcur_in;
   logic [bfc_pkg::COLSUM_W-1:0] cap_ff, cap_in;

   // Stage-2 arithmetic
   logic [bfc_pkg::PIX_W-1:0]    up_px, mid_px;
   logic [bfc_pkg::COLSUM_W-1:0] n_col, dr_col, wr_cap;
   logic [bfc_pkg::SUM_W-1:0]    sum_prev, sum_cur, sum_drain;

   // Result queue
   bfc_pkg::push_type            push;
   bfc_pkg::result_type          head;
   logic                         q_not_empty;
   logic [bfc_pkg::FIFO_CNT_W-1:0] q_count;
   logic                         rsp_take;
   logic [bfc_pkg::FIFO_CNT_W:0] pending;

   // ---------------------------------------------------------------------
   // Register writes
   assign csr_ready = 1'b1;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid) begin
         case (csr_index)
            bfc_pkg::REG_FRAME_WIDTH: begin
               frame_width_in = csr_wdata;
            end
            bfc_pkg::REG_FRAME_HEIGHT: begin
               frame_height_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign w_eff = bfc_pkg::eff_size(frame_width_ff, bfc_pkg::CFG_W'(bfc_pkg::MAX_WIDTH));
   assign h_eff = bfc_pkg::eff_size(frame_height_ff, bfc_pkg::CFG_W'(bfc_pkg::MAX_HEIGHT));

   // ---------------------------------------------------------------------
   // Stall when the queue could overflow with what is already in flight
   always_comb begin
      pending = (bfc_pkg::FIFO_CNT_W+1)'(q_count)
              + (bfc_pkg::FIFO_CNT_W+1)'(s2_ff.nres)
              + (bfc_pkg::FIFO_CNT_W+1)'(s3_ff.valid_a)
              + (bfc_pkg::FIFO_CNT_W+1)'(s3_ff.valid_b)
              + (bfc_pkg::FIFO_CNT_W+1)'(2);
      req_stall = (pending > (bfc_pkg::FIFO_CNT_W+1)'(bfc_pkg::FIFO_DEPTH));
   end

   assign req_take = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Stage 1: decode the word, step the counters, address the line memory
   always_comb begin
      logic                      row_end;
      logic                      d_last;
      s2_in        = '0;
      s2_in.op     = bfc_pkg::OP_NONE;
      in_row_in    = in_row_ff;
      in_col_in    = in_col_ff;
      drain_col_in = drain_col_ff;
      draining_in  = draining_ff;
      row_end      = (({1'b0, in_col_ff} + bfc_pkg::CFG_W'(1)) >= w_eff);
      d_last       = (({1'b0, drain_col_ff} + bfc_pkg::CFG_W'(1)) >= w_eff);
      rd_addr      = in_col_ff;

      if (req_type == bfc_pkg::REQ_FLUSH) begin
         rd_addr = d_last ? drain_col_ff : drain_col_ff + bfc_pkg::COL_W'(1);
      end

      if (req_take) begin
         if (req_type == bfc_pkg::REQ_FLUSH) begin
            if (draining_ff) begin
               // Drain one column of the last row
               s2_in.op   = bfc_pkg::OP_DRAIN;
               s2_in.addr = rd_addr;
               s2_in.last = d_last;
               s2_in.col  = drain_col_ff;
               s2_in.row  = in_row_ff;
               s2_in.nres = 2'd1;
               if (d_last) begin
                  draining_in  = 1'b0;
                  drain_col_in = '0;
                  in_row_in    = '0;
                  in_col_in    = '0;
               end else begin
                  drain_col_in = drain_col_ff + bfc_pkg::COL_W'(1);
               end
            end
         end else if (!draining_ff) begin
            // Pixel of the current row
            s2_in.op          = bfc_pkg::OP_PIXEL;
            s2_in.addr        = in_col_ff;
            s2_in.px          = req_pixel_in;
            s2_in.row0        = (in_row_ff == '0);
            s2_in.col_first   = (in_col_ff == '0);
            s2_in.emit_prev   = !s2_in.row0 && !s2_in.col_first;
            s2_in.emit_cur    = !s2_in.row0 && row_end;
            s2_in.col         = in_col_ff;
            s2_in.row         = in_row_ff - bfc_pkg::ROW_W'(1);
            s2_in.nres        = 2'(s2_in.emit_prev) + 2'(s2_in.emit_cur);
            s2_in.drain_start = row_end &&
                                (({1'b0, in_row_ff} + bfc_pkg::CFG_W'(1)) >= h_eff);
            if (row_end) begin
               in_col_in = '0;
               if (s2_in.drain_start) begin
                  draining_in  = 1'b1;
                  drain_col_in = '0;
               end else begin
                  in_row_in = in_row_ff + bfc_pkg::ROW_W'(1);
               end
            end else begin
               in_col_in = in_col_ff + bfc_pkg::COL_W'(1);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Line memory: write back from stage 2, read for stage 1
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[s2_ff.addr] <= wr_word;
      end
      ram_rd_ff <= line_mem[rd_addr];
   end

   // ---------------------------------------------------------------------
   // Stage 2: column sums, window sums, write back
   always_comb begin
      rd_word = fwd_hit_ff ? fwd_word_ff : ram_rd_ff;
      up_px   = rd_word[bfc_pkg::PIX_W +: bfc_pkg::PIX_W];
      mid_px  = rd_word[0 +: bfc_pkg::PIX_W];
      n_col   = bfc_pkg::COLSUM_W'(up_px) + bfc_pkg::COLSUM_W'(mid_px)
              + bfc_pkg::COLSUM_W'(s2_ff.px);

      // Row 0 fills both lines; later rows shift middle up
      wr_en   = (s2_ff.op == bfc_pkg::OP_PIXEL);
      wr_word = s2_ff.row0 ? {s2_ff.px, s2_ff.px} : {mid_px, s2_ff.px};
      wr_cap  = bfc_pkg::COLSUM_W'(wr_word[bfc_pkg::PIX_W +: bfc_pkg::PIX_W])
              + (bfc_pkg::COLSUM_W'(wr_word[0 +: bfc_pkg::PIX_W]) << 1);

      fwd_hit_in  = wr_en && (s2_ff.addr == rd_addr);
      fwd_word_in = wr_word;

      // Column 0 of the drain window is kept as it is written
      cap_in = cap_ff;
      if (wr_en && (s2_ff.addr == '0)) begin
         cap_in = wr_cap;
      end

      sum_prev  = bfc_pkg::SUM_W'(cs1_ff) + bfc_pkg::SUM_W'(cs2_ff)
                + bfc_pkg::SUM_W'(n_col);
      sum_cur   = s2_ff.col_first
                ? bfc_pkg::SUM_W'(n_col) + (bfc_pkg::SUM_W'(n_col) << 1)
                : bfc_pkg::SUM_W'(cs2_ff) + (bfc_pkg::SUM_W'(n_col) << 1);
      dr_col    = s2_ff.last ? dcur_ff
                : bfc_pkg::COLSUM_W'(up_px) + (bfc_pkg::COLSUM_W'(mid_px) << 1);
      sum_drain = bfc_pkg::SUM_W'(dprev_ff) + bfc_pkg::SUM_W'(dcur_ff)
                + bfc_pkg::SUM_W'(dr_col);

      // Slide the window
      cs0_in = cs0_ff;
      cs1_in = cs1_ff;
      cs2_in = cs2_ff;
      if ((s2_ff.op == bfc_pkg::OP_PIXEL) && !s2_ff.row0) begin
         if (s2_ff.col_first) begin
            cs0_in = n_col;
            cs1_in = n_col;
            cs2_in = n_col;
         end else if (s2_ff.emit_cur) begin
            // Right edge repeats the current column
            cs0_in = cs2_ff;
            cs1_in = n_col;
            cs2_in = n_col;
         end else begin
            cs0_in = cs1_ff;
            cs1_in = cs2_ff;
            cs2_in = n_col;
         end
      end

      // Slide the drain window, or load it when the drain starts
      dprev_in = dprev_ff;
      dcur_in  = dcur_ff;
      if ((s2_ff.op == bfc_pkg::OP_PIXEL) && s2_ff.drain_start) begin
         dprev_in = cap_in;
         dcur_in  = cap_in;
      end else if (s2_ff.op == bfc_pkg::OP_DRAIN) begin
         dprev_in = dcur_ff;
         dcur_in  = dr_col;
      end

      // Hand results to stage 3
      s3_in = '0;
      case (s2_ff.op)
         bfc_pkg::OP_PIXEL: begin
            s3_in.valid_a   = s2_ff.emit_prev;
            s3_in.a.sum     = sum_prev;
            s3_in.a.col     = s2_ff.col - bfc_pkg::COL_W'(1);
            s3_in.a.row     = s2_ff.row;
            s3_in.a.run_end = !s2_ff.emit_cur;
            s3_in.valid_b   = s2_ff.emit_cur;
            s3_in.b.sum     = sum_cur;
            s3_in.b.col     = s2_ff.col;
            s3_in.b.row     = s2_ff.row;
            s3_in.b.run_end = 1'b1;
         end
         bfc_pkg::OP_DRAIN: begin
            s3_in.valid_a   = 1'b1;
            s3_in.a.sum     = sum_drain;
            s3_in.a.col     = s2_ff.col;
            s3_in.a.row     = s2_ff.row;
            s3_in.a.done    = s2_ff.last;
            s3_in.a.run_end = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Stage 3: divide by nine and push into the queue
   always_comb begin
      push                 = '0;
      push.valid_a         = s3_ff.valid_a;
      push.a.pixel_out     = bfc_pkg::div9(s3_ff.a.sum);
      push.a.out_col       = s3_ff.a.col;
      push.a.out_row       = s3_ff.a.row;
      push.a.frame_done    = s3_ff.a.done;
      push.a.run_end       = s3_ff.a.run_end;
      push.valid_b         = s3_ff.valid_b;
      push.b.pixel_out     = bfc_pkg::div9(s3_ff.b.sum);
      push.b.out_col       = s3_ff.b.col;
      push.b.out_row       = s3_ff.b.row;
      push.b.frame_done    = s3_ff.b.done;
      push.b.run_end       = s3_ff.b.run_end;
   end

   // ---------------------------------------------------------------------
   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= bfc_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= bfc_pkg::FRAME_HEIGHT_RESET;
         in_row_ff       <= '0;
         in_col_ff       <= '0;
         drain_col_ff    <= '0;
         draining_ff     <= 1'b0;
         s2_ff           <= '0;
         s3_ff           <= '0;
         fwd_hit_ff      <= 1'b0;
         cs0_ff          <= '0;
         cs1_ff          <= '0;
         cs2_ff          <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         in_row_ff       <= in_row_in;
         in_col_ff       <= in_col_in;
         drain_col_ff    <= drain_col_in;
         draining_ff     <= draining_in;
         s2_ff           <= s2_in;
         s3_ff           <= s3_in;
         fwd_hit_ff      <= fwd_hit_in;
         cs0_ff          <= cs0_in;
         cs1_ff          <= cs1_in;
         cs2_ff          <= cs2_in;
      end
   end

   // Data registers
   always_ff @(posedge clock) begin
      fwd_word_ff <= fwd_word_in;
      dprev_ff    <= dprev_in;
      dcur_ff     <= dcur_in;
      cap_ff      <= cap_in;
   end

   // ---------------------------------------------------------------------
   // Result queue and output port
   assign rsp_take = q_not_empty && !rsp_stall;

   bfc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_take),
      .head      (head),
      .not_empty (q_not_empty),
      .count     (q_count)
   );

   assign rsp_valid      = q_not_empty;
   assign rsp_pixel_out  = head.pixel_out;
   assign rsp_out_col    = head.out_col;
   assign rsp_out_row    = head.out_row;
   assign rsp_frame_done = head.frame_done;
   assign rsp_run_end    = head.run_end;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking bench for the 3x3 clamped box filter: a line-store predictor
// follows every request word and each result word is compared against it.
// Depends on bfc_pkg and box_filter_3x3_clamped.

module testbench;
   import bfc_pkg::*;

   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_WORDS  = 250;

   typedef enum int {
      STALL_NONE,
      STALL_SCATTER,
      STALL_RUNS
   } stall_style_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_type;
   logic [PIX_W-1:0]     req_pixel_in;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [PIX_W-1:0]     rsp_pixel_out;
   logic [COL_W-1:0]     rsp_out_col;
   logic [ROW_W-1:0]     rsp_out_row;
   logic                 rsp_frame_done;
   logic                 rsp_run_end;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   // Filter state as the predictor sees it
   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;
   logic [PIX_W-1:0] upper_row [MAX_WIDTH];
   logic [PIX_W-1:0] middle_row [MAX_WIDTH];
   logic [PIX_W-1:0] window [9];          // [3*column + row], column 0 leftmost
   int unsigned      row_at;
   int unsigned      col_at;
   int unsigned      drain_at;
   bit               draining;
   result_type       mean_queue [$];

   // Run statistics
   int unsigned words_sent = 0;
   int unsigned means_checked = 0;
   int unsigned frames_seen = 0;
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles = 0;

   // Idling controls
   int unsigned     gap_max = 0;
   int unsigned     burst_max = 1;
   int unsigned     burst_left = 0;
   int unsigned     stall_left = 0;
   stall_style_type stall_style = STALL_NONE;

   box_filter_3x3_clamped i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_done (rsp_frame_done),
      .rsp_run_end    (rsp_run_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #1 clock = ~clock;

   // Size register as the filter uses it: zero means one, clip at the maximum
   function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v,
                                              input int unsigned limit);
      if (v == '0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic void shift_in(input logic [PIX_W-1:0] u, input logic [PIX_W-1:0] m,
                                    input logic [PIX_W-1:0] l);
      for (int i = 0; i < 6; i++) window[i] = window[i + 3];
      window[6] = u;
      window[7] = m;
      window[8] = l;
   endfunction

   function automatic int unsigned window_total();
      int unsigned s;
      s = 0;
      for (int i = 0; i < 9; i++) s += 32'(window[i]);
      return s;
   endfunction

   function automatic result_type make_mean(input int unsigned sum, input int unsigned col,
                                            input int unsigned row, input bit done);
      result_type res;
      res.pixel_out  = PIX_W'(sum / 9);
      res.out_col    = COL_W'(col);
      res.out_row    = ROW_W'(row);
      res.frame_done = done;
      res.run_end    = 1'b0;
      return res;
   endfunction

   // Advance the filter by one request word and queue the means it yields
   function automatic void filter_word(input logic kind, input logic [PIX_W-1:0] px);
      int unsigned w, h, c, d, l, r, s, n;
      logic [PIX_W-1:0] u, m;
      bit row_end;
      result_type outs [2];
      w = clamp_size(width_reg, MAX_WIDTH);
      h = clamp_size(height_reg, MAX_HEIGHT);
      n = 0;
      if (kind == REQ_FLUSH) begin
         // flush: emit one column of the last row, drop when nothing is pending
         if (draining) begin
            d = drain_at % MAX_WIDTH;
            row_end = (d + 1 >= w);
            l = (d > 0) ? d - 1 : 0;
            r = row_end ? d : d + 1;
            s = 32'(upper_row[l]) + 32'(upper_row[d]) + 32'(upper_row[r])
              + 2 * (32'(middle_row[l]) + 32'(middle_row[d]) + 32'(middle_row[r]));
            outs[0] = make_mean(s, d, row_at, row_end);
            n = 1;
            if (row_end) begin
               draining = 0;
               drain_at = 0;
               row_at = 0;
               col_at = 0;
               frames_seen++;
            end else begin
               drain_at = d + 1;
            end
         end
      end else if (!draining) begin
         c = col_at % MAX_WIDTH;
         row_end = (c + 1 >= w);
         if (row_at == 0) begin
            upper_row[c] = px;
            middle_row[c] = px;
         end else begin
            u = upper_row[c];
            m = middle_row[c];
            // left edge repeats the first column
            if (c == 0) begin
               for (int i = 0; i < 3; i++) begin
                  window[3 * i]     = u;
                  window[3 * i + 1] = m;
                  window[3 * i + 2] = px;
               end
            end else begin
               shift_in(u, m, px);
               outs[n] = make_mean(window_total(), c - 1, row_at - 1, 1'b0);
               n++;
            end
            // right edge repeats the last column
            if (row_end) begin
               shift_in(u, m, px);
               outs[n] = make_mean(window_total(), c, row_at - 1, 1'b0);
               n++;
            end
            upper_row[c] = m;
            middle_row[c] = px;
         end
         if (row_end) begin
            col_at = 0;
            if (row_at + 1 >= h) begin
               draining = 1;
               drain_at = 0;
            end else begin
               row_at++;
            end
         end else begin
            col_at = c + 1;
         end
      end
      if (n > 0) begin
         outs[n - 1].run_end = 1'b1;
         for (int i = 0; i < n; i++) mean_queue.push_back(outs[i]);
      end
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel();
      case ($urandom_range(7, 0))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] seen,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("mismatch at result %0d: %s got %0d, expected %0d",
               means_checked, what, seen, want);
   endtask

   // Send one request word, with bursts and gaps between them
   task automatic send_word(input logic kind, input logic [PIX_W-1:0] px);
      int unsigned gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 1);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(burst_max, 1);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_type <= kind;
      req_pixel_in <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      filter_word(kind, px);
      words_sent++;
   endtask

   // Hold requests until every queued mean is out and the pipeline is empty
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (mean_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_FRAME_WIDTH) width_reg = value;
      else height_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_frame(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val);
      quiesce();
      write_reg(REG_FRAME_WIDTH, w_val);
      write_reg(REG_FRAME_HEIGHT, h_val);
   endtask

   // One whole frame and its drain, optionally salted with words that are dropped
   task automatic run_frame(input bit noisy);
      int unsigned w, h;
      w = clamp_size(width_reg, MAX_WIDTH);
      h = clamp_size(height_reg, MAX_HEIGHT);
      for (int unsigned p = 0; p < w * h; p++) begin
         if (noisy && $urandom_range(15, 0) == 0) send_word(REQ_FLUSH, PIX_W'($urandom));
         send_word(REQ_PIXEL, pick_pixel());
      end
      for (int unsigned d = 0; d < w; d++) begin
         if (noisy && $urandom_range(9, 0) == 0) send_word(REQ_PIXEL, pick_pixel());
         send_word(REQ_FLUSH, PIX_W'($urandom));
      end
      if (noisy && $urandom_range(3, 0) == 0) send_word(REQ_FLUSH, PIX_W'($urandom));
   endtask

   // Tiny frames, extreme pixels, stray flushes and a pixel during the drain
   task automatic test_small_frames();
      gap_max = 3;
      burst_max = 4;
      stall_style = STALL_RUNS;
      set_frame(CFG_W'(3), CFG_W'(2));
      send_word(REQ_FLUSH, 8'hFF);
      send_word(REQ_PIXEL, 8'hFF);
      send_word(REQ_PIXEL, 8'h00);
      send_word(REQ_PIXEL, 8'hFF);
      send_word(REQ_PIXEL, 8'h00);
      send_word(REQ_PIXEL, 8'hFF);
      send_word(REQ_PIXEL, 8'h00);
      send_word(REQ_PIXEL, 8'h11);
      repeat (3) send_word(REQ_FLUSH, 8'h00);
      send_word(REQ_FLUSH, 8'hA5);
      // zero sizes act as a single pixel frame
      set_frame('0, '0);
      send_word(REQ_PIXEL, 8'hFF);
      send_word(REQ_FLUSH, 8'h00);
      // two columns by three rows, all white then black bottom row
      set_frame(CFG_W'(2), CFG_W'(3));
      repeat (4) send_word(REQ_PIXEL, 8'hFF);
      repeat (2) send_word(REQ_PIXEL, 8'h00);
      repeat (2) send_word(REQ_FLUSH, 8'h5A);
   endtask

   // Random small frames with random idling per phase
   task automatic test_random_frames();
      int unsigned start;
      logic [CFG_W-1:0] w_val, h_val;
      start = words_sent;
      // first phase runs without any idling
      gap_max = 0;
      burst_max = 1;
      stall_style = STALL_NONE;
      while (words_sent - start < RANDOM_WORDS) begin
         case ($urandom_range(7, 0))
            0: w_val = '0;
            1: w_val = CFG_W'($urandom_range(3, 2));
            default: w_val = CFG_W'($urandom_range(24, 1));
         endcase
         h_val = ($urandom_range(9, 0) == 0) ? '0 : CFG_W'($urandom_range(8, 1));
         set_frame(w_val, h_val);
         repeat ($urandom_range(3, 1)) run_frame(1'b1);
         case ($urandom_range(3, 0))
            0: gap_max = 0;
            1: gap_max = 2;
            2: gap_max = 6;
            default: gap_max = 16;
         endcase
         burst_max = $urandom_range(24, 1);
         stall_style = stall_style_type'($urandom_range(2, 0));
      end
   endtask

   // Largest frame: full width, clipped from the top size code, one row
   task automatic test_largest_frames();
      gap_max = 2;
      burst_max = 32;
      stall_style = STALL_RUNS;
      set_frame('1, CFG_W'(1));
      run_frame(1'b0);
   endtask

   // Result side stall pattern
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_style)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_SCATTER: rsp_stall <= ($urandom_range(3, 0) == 0);
            default: begin
               if ($urandom_range(7, 0) == 0) begin
                  stall_left = $urandom_range(11, 0);
                  rsp_stall <= 1'b1;
               end else begin
                  rsp_stall <= 1'b0;
               end
            end
         endcase
      end
   end

   // Compare each accepted result word with the oldest queued mean
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (mean_queue.size() == 0) begin
            report_mismatch("result with nothing queued, pixel_out", rsp_pixel_out, 0);
         end else begin
            want = mean_queue.pop_front();
            if (rsp_pixel_out !== want.pixel_out)
               report_mismatch("pixel_out", rsp_pixel_out, want.pixel_out);
            if (rsp_out_col !== want.out_col)
               report_mismatch("out_col", rsp_out_col, want.out_col);
            if (rsp_out_row !== want.out_row)
               report_mismatch("out_row", rsp_out_row, want.out_row);
            if (rsp_frame_done !== want.frame_done)
               report_mismatch("frame_done", rsp_frame_done, want.frame_done);
            if (rsp_run_end !== want.run_end)
               report_mismatch("run_end", rsp_run_end, want.run_end);
            means_checked++;
         end
      end
   end

   // Watchdog: end the run when no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no word moved for %0d cycles, %0d means still queued",
                     IDLE_LIMIT, mean_queue.size());
            $display("FAIL box_filter_3x3_clamped");
            $finish;
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_PIXEL;
      req_pixel_in = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_FRAME_WIDTH;
      csr_wdata = '0;
      // predictor starts from the reset state
      width_reg = FRAME_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         upper_row[i] = '0;
         middle_row[i] = '0;
      end
      for (int i = 0; i < 9; i++) window[i] = '0;
      row_at = 0;
      col_at = 0;
      drain_at = 0;
      draining = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_small_frames();
      test_random_frames();
      test_largest_frames();
      quiesce();

      $display("covered %0d request words and %0d filtered pixels over %0d frames,",
               words_sent, means_checked, frames_seen);
      $display("from single pixel frames up to a full 512 column row, with stalls and gaps");
      if (mismatch_count == 0) begin
         $display("PASS box_filter_3x3_clamped");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAIL box_filter_3x3_clamped");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/bfc_pkg.sv
hw/rtl/bfc_rsp_fifo.sv
hw/rtl/box_filter_3x3_clamped.sv
dv/testbench.sv
